[hw/rtl/charge_supervisor_macros.svh]
// Assertion helpers for the charge supervisor.
// Each expects clk and arst_n in scope.
`ifndef CHARGE_SUPERVISOR_MACROS_SVH
`define CHARGE_SUPERVISOR_MACROS_SVH

// Consequent must hold in the same cycle.
`define CS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the next cycle.
`define CS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cs_pkg.sv]
`timescale 1ns / 1ps

package cs_pkg;

	localparam int unsigned HoldW   = 16;
	localparam int unsigned SilW    = 16;
	localparam int unsigned ManW    = 24;
	localparam int unsigned SeqW    = 8;
	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutDataW = 24;
	localparam int unsigned ApbAddrW = 4;
	localparam int unsigned ApbDataW = 32;

	// reset values of the timing registers
	localparam logic [HoldW-1:0] PressTimeRst     = 16'd500;
	localparam logic [HoldW-1:0] LongPressTimeRst = 16'd5000;
	localparam logic [SilW-1:0]  HbLimitRst       = 16'd10000;
	localparam logic [ManW-1:0]  ManualLimitRst   = 24'd7200000;

	typedef enum logic [1:0] {
		REG_PRESS_TIME      = 2'd0,
		REG_LONG_PRESS_TIME = 2'd1,
		REG_HB_LIMIT        = 2'd2,
		REG_MANUAL_LIMIT    = 2'd3
	} cs_reg_t;

	typedef enum logic [1:0] {
		PRESS_RELEASED = 2'd0,
		PRESS_PUSHED   = 2'd1,
		PRESS_LONG     = 2'd2
	} press_mode_t;

	typedef enum logic [1:0] {
		FAULT_NONE           = 2'd0,
		FAULT_MANUAL_TIMEOUT = 2'd1,
		FAULT_HB_TIMEOUT     = 2'd2,
		FAULT_OVERHEAT       = 2'd3
	} fault_t;

	typedef struct packed {
		logic [HoldW-1:0] press_time;
		logic [HoldW-1:0] long_press_time;
		logic [SilW-1:0]  hb_limit;
		logic [ManW-1:0]  manual_limit;
	} cs_cfg_t;

	typedef struct packed {
		logic            switch_level;
		logic            overheat;
		logic            hb_arrived;
		logic            hb_enable;
		logic [SeqW-1:0] hb_seq;
	} cs_item_t;

	typedef struct packed {
		logic             switch_seen;
		logic             switch_last;
		logic [HoldW-1:0] hold_count;
		press_mode_t      press_mode;
		logic             charge_on;
		logic             auto_selected;
		logic [SilW-1:0]  silence_count;
		logic [ManW-1:0]  manual_count;
		fault_t           fault;
	} cs_state_t;

	typedef struct packed {
		logic            ac_relay;
		logic            dc_relay;
		logic            fan_on;
		logic            manual_active;
		logic            auto_active;
		fault_t          fault_code;
		press_mode_t     press_state;
		logic            reply_valid;
		logic [SeqW-1:0] reply_seq;
		logic            reply_auto;
	} cs_result_t;

endpackage

[hw/rtl/charge_supervisor.sv]
`timescale 1ns / 1ps
// Charging supervisor, one request per 1 ms tick. Each request carries the
// switch level, the overheat flag and an optional heartbeat; each produces
// exactly one result with the relay, fan and status lines, the latched fault
// code, the qualified switch state and the heartbeat reply. Throughput is one
// request per clock unless the result side stalls; each request passes through
// the input register, then the result register. The rate is set by the single
// state-update stage, whose state feeds straight back into the next request's
// logic. The input side keeps accepting while a result waits, as long as the
// result register will free up on the same edge. Timing registers sit on the
// APB port at 0x0 (press time), 0x4 (long press time), 0x8 (heartbeat limit)
// and 0xC (manual limit); write them only while the block is idle.
`include "charge_supervisor_macros.svh"

module charge_supervisor import cs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	// [0] switch_level, [1] overheat, [2] heartbeat_arrived, [3] heartbeat_enable,
	// [11:4] heartbeat_seq, [15:12] zero
	input  logic [InDataW-1:0]  s_tdata,
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] ac_relay, [1] dc_relay, [2] fan_on, [3] manual_active, [4] auto_active,
	// [6:5] fault_code, [8:7] press_state, [9] reply_valid, [17:10] reply_seq,
	// [18] reply_auto, [23:19] zero
	output logic [OutDataW-1:0] m_tdata,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	cs_cfg_t    cfg_q;
	cs_state_t  state_q;
	cs_state_t  state_nx;
	cs_item_t   item_s1;
	logic       valid_s1;
	cs_result_t res_nx;
	cs_result_t res_s2;
	logic       valid_s2;
	logic       out_free;
	logic       adv_s1;
	logic       cfg_wr;
	cs_reg_t    reg_sel;

	// ---------------- configuration ----------------
	assign pready  = 1'b1;
	assign reg_sel = cs_reg_t'(paddr[ApbAddrW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_time      <= PressTimeRst;
			cfg_q.long_press_time <= LongPressTimeRst;
			cfg_q.hb_limit        <= HbLimitRst;
			cfg_q.manual_limit    <= ManualLimitRst;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_PRESS_TIME:      cfg_q.press_time      <= pwdata[HoldW-1:0];
				REG_LONG_PRESS_TIME: cfg_q.long_press_time <= pwdata[HoldW-1:0];
				REG_HB_LIMIT:        cfg_q.hb_limit        <= pwdata[SilW-1:0];
				REG_MANUAL_LIMIT:    cfg_q.manual_limit    <= pwdata[ManW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PRESS_TIME:      prdata = ApbDataW'(cfg_q.press_time);
			REG_LONG_PRESS_TIME: prdata = ApbDataW'(cfg_q.long_press_time);
			REG_HB_LIMIT:        prdata = ApbDataW'(cfg_q.hb_limit);
			REG_MANUAL_LIMIT:    prdata = ApbDataW'(cfg_q.manual_limit);
		endcase
	end

	// ---------------- handshake ----------------
	// result register frees when empty or being taken; the input register moves
	// into it on the same edge, so a request can enter every cycle unless stalled
	assign out_free = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.switch_level <= s_tdata[0];
			item_s1.overheat     <= s_tdata[1];
			item_s1.hb_arrived   <= s_tdata[2];
			item_s1.hb_enable    <= s_tdata[3];
			item_s1.hb_seq       <= s_tdata[SeqW+3:4];
		end
	end

	// ---------------- tick logic ----------------
	cs_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.nx   (state_nx),
		.res  (res_nx)
	);

	// supervisor state advances once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.switch_seen   <= 1'b0;
			state_q.switch_last   <= 1'b1;
			state_q.hold_count    <= '0;
			state_q.press_mode    <= PRESS_RELEASED;
			state_q.charge_on     <= 1'b0;
			state_q.auto_selected <= 1'b0;
			state_q.silence_count <= '0;
			state_q.manual_count  <= '0;
			state_q.fault         <= FAULT_NONE;
		end else if (adv_s1) begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nx;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0,
		res_s2.reply_auto, res_s2.reply_seq, res_s2.reply_valid,
		res_s2.press_state, res_s2.fault_code, res_s2.auto_active,
		res_s2.manual_active, res_s2.fan_on, res_s2.dc_relay, res_s2.ac_relay};

	// ---------------- checks ----------------
	`CS_ASSERT_SAME(a_auto_needs_charge, state_q.auto_selected, state_q.charge_on, "auto selected while charging is off")
	`CS_ASSERT_SAME(a_push_is_manual, state_q.press_mode == PRESS_PUSHED, state_q.charge_on && !state_q.auto_selected, "pushed switch without manual charging")
	`CS_ASSERT_NEXT(a_result_follows, adv_s1, valid_s2, "request moved on but no result registered")

endmodule

[hw/rtl/cs_step.sv]
`timescale 1ns / 1ps

// One tick of the supervisor: next state and result from current state and request.
module cs_step import cs_pkg::*; (
	input  cs_cfg_t    cfg,
	input  cs_state_t  st,
	input  cs_item_t   item,
	output cs_state_t  nx,
	output cs_result_t res
);

	logic [HoldW-1:0] hold_inc;
	logic [SilW-1:0]  sil_inc;
	logic             manual_on;

	always_comb begin
		nx = st;
		hold_inc = (st.hold_count == '1) ? st.hold_count : st.hold_count + 1'b1;
		sil_inc  = (st.silence_count == '1) ? st.silence_count : st.silence_count + 1'b1;

		// switch qualification
		if (!st.switch_seen || item.switch_level != st.switch_last) begin
			nx.switch_seen = 1'b1;
			nx.switch_last = item.switch_level;
			nx.hold_count  = '0;
		end else if (!item.switch_level) begin
			nx.hold_count = hold_inc;
			if (hold_inc > cfg.long_press_time) begin
				nx.press_mode = PRESS_LONG;
			end else if (hold_inc > cfg.press_time) begin
				nx.press_mode = PRESS_PUSHED;
			end
		end else begin
			nx.press_mode = PRESS_RELEASED;
		end

		// timers
		nx.silence_count = sil_inc;
		manual_on = st.charge_on && !st.auto_selected;
		if (manual_on && st.manual_count != '1) begin
			nx.manual_count = st.manual_count + 1'b1;
		end

		// supervision: overheat wins over heartbeat silence
		if (st.charge_on && st.auto_selected) begin
			if (item.overheat) begin
				nx.charge_on     = 1'b0;
				nx.auto_selected = 1'b0;
				nx.fault         = FAULT_OVERHEAT;
			end else if (sil_inc > cfg.hb_limit) begin
				nx.charge_on     = 1'b0;
				nx.auto_selected = 1'b0;
				nx.fault         = FAULT_HB_TIMEOUT;
			end
		end
		if (manual_on && nx.manual_count > cfg.manual_limit) begin
			nx.charge_on     = 1'b0;
			nx.auto_selected = 1'b0;
			nx.manual_count  = '0;
			nx.fault         = FAULT_MANUAL_TIMEOUT;
		end

		// switch action
		case (nx.press_mode)
			PRESS_PUSHED: begin
				nx.charge_on     = 1'b1;
				nx.auto_selected = 1'b0;
				nx.manual_count  = '0;
				nx.fault         = FAULT_NONE;
			end
			PRESS_LONG: begin
				nx.charge_on     = 1'b0;
				nx.auto_selected = 1'b0;
				nx.manual_count  = '0;
			end
			default: begin
			end
		endcase

		// heartbeat: clears the silence count; its on/off request is ignored while manual charging is on
		if (item.hb_arrived) begin
			nx.silence_count = '0;
			if (!(nx.charge_on && !nx.auto_selected)) begin
				if (item.hb_enable && !item.overheat) begin
					nx.charge_on     = 1'b1;
					nx.auto_selected = 1'b1;
					nx.fault         = FAULT_NONE;
				end else begin
					nx.charge_on     = 1'b0;
					nx.auto_selected = 1'b0;
				end
			end
		end

		res.ac_relay      = nx.charge_on;
		res.dc_relay      = nx.charge_on && nx.auto_selected;
		res.fan_on        = nx.charge_on;
		res.manual_active = nx.charge_on && !nx.auto_selected;
		res.auto_active   = nx.charge_on && nx.auto_selected;
		res.fault_code    = nx.fault;
		res.press_state   = nx.press_mode;
		res.reply_valid   = item.hb_arrived;
		res.reply_seq     = item.hb_arrived ? item.hb_seq : '0;
		res.reply_auto    = item.hb_arrived && nx.charge_on && nx.auto_selected;
	end

endmodule

[bench/charge_supervisor_tb.sv]
`timescale 1ns / 1ps

module charge_supervisor_tb import cs_pkg::*; ();

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned HoldOffCycles = 200;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// [0] switch_level, [1] overheat, [2] heartbeat_arrived, [3] heartbeat_enable,
	// [11:4] heartbeat_seq, [15:12] zero
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	// [0] ac_relay, [1] dc_relay, [2] fan_on, [3] manual_active, [4] auto_active,
	// [6:5] fault_code, [8:7] press_state, [9] reply_valid, [17:10] reply_seq,
	// [18] reply_auto, [23:19] zero
	logic [OutDataW-1:0] m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	charge_supervisor u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// ---------------------------------------------------------------------
	// Supervisor model: own copy of the timing limits and charger state
	// ---------------------------------------------------------------------
	typedef struct {
		bit               seen;      // a switch sample has been latched
		bit               last;      // latched switch level
		logic [HoldW-1:0] hold;      // ticks the level has been held
		press_mode_t      mode;
		bit               on;        // charging enabled
		bit               auto_sel;  // auto (heartbeat) rather than manual
		logic [SilW-1:0]  silence;   // ticks since last heartbeat
		logic [ManW-1:0]  man_time;  // ticks of manual charging
		fault_t           fault;
	} charger_t;

	charger_t         chg;
	logic [HoldW-1:0] lim_press;
	logic [HoldW-1:0] lim_long;
	logic [SilW-1:0]  lim_hb;
	logic [ManW-1:0]  lim_man;

	cs_result_t expected_results[$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned burst_left;
	int          budget;        // requests left in the current random mix
	bit          hold_off_req;  // asks the receiver for one long stall

	function automatic void reset_charger();
		lim_press = PressTimeRst;
		lim_long = LongPressTimeRst;
		lim_hb = HbLimitRst;
		lim_man = ManualLimitRst;
		chg.seen = 1'b0;
		chg.last = 1'b1;
		chg.hold = '0;
		chg.mode = PRESS_RELEASED;
		chg.on = 1'b0;
		chg.auto_sel = 1'b0;
		chg.silence = '0;
		chg.man_time = '0;
		chg.fault = FAULT_NONE;
	endfunction

	function automatic void set_manual(bit want);
		chg.on = want;
		chg.auto_sel = 1'b0;
		chg.man_time = '0;
		if (want)
			chg.fault = FAULT_NONE;
	endfunction

	// heartbeats are ignored while manual charging owns the relays
	function automatic void arm_auto(bit want, bit hot);
		if (chg.on && !chg.auto_sel)
			return;
		if (want && !hot) begin
			chg.on = 1'b1;
			chg.auto_sel = 1'b1;
			chg.fault = FAULT_NONE;
		end else begin
			chg.on = 1'b0;
			chg.auto_sel = 1'b0;
		end
	endfunction

	function automatic cs_result_t supervise_tick(cs_item_t it);
		cs_result_t r;
		bit         reply_auto;
		reply_auto = 1'b0;

		// switch qualification; mode holds over on the tick of a level change
		if (!chg.seen || it.switch_level != chg.last) begin
			chg.seen = 1'b1;
			chg.last = it.switch_level;
			chg.hold = '0;
		end else if (!it.switch_level) begin
			if (chg.hold != '1)
				chg.hold++;
			if (chg.hold > lim_long)
				chg.mode = PRESS_LONG;
			else if (chg.hold > lim_press)
				chg.mode = PRESS_PUSHED;
		end else begin
			chg.mode = PRESS_RELEASED;
		end

		// timers, supervision
		if (chg.silence != '1)
			chg.silence++;
		if (chg.on && !chg.auto_sel && chg.man_time != '1)
			chg.man_time++;
		if (chg.on && chg.auto_sel) begin
			if (chg.silence > lim_hb) begin
				arm_auto(1'b0, it.overheat);
				chg.fault = FAULT_HB_TIMEOUT;
			end
			// overheat wins over a simultaneous heartbeat timeout
			if (it.overheat) begin
				arm_auto(1'b0, it.overheat);
				chg.fault = FAULT_OVERHEAT;
			end
		end
		if (chg.on && !chg.auto_sel && chg.man_time > lim_man) begin
			set_manual(1'b0);
			chg.fault = FAULT_MANUAL_TIMEOUT;
		end

		// switch action
		if (chg.mode == PRESS_PUSHED)
			set_manual(1'b1);
		else if (chg.mode == PRESS_LONG)
			set_manual(1'b0);

		// heartbeat
		if (it.hb_arrived) begin
			arm_auto(it.hb_enable, it.overheat);
			reply_auto = chg.on && chg.auto_sel;
			chg.silence = '0;
		end

		r = '0;
		r.ac_relay = chg.on;
		r.dc_relay = chg.on && chg.auto_sel;
		r.fan_on = chg.on;
		r.manual_active = chg.on && !chg.auto_sel;
		r.auto_active = chg.on && chg.auto_sel;
		r.fault_code = chg.fault;
		r.press_state = chg.mode;
		r.reply_valid = it.hb_arrived;
		r.reply_seq = it.hb_arrived ? it.hb_seq : '0;
		r.reply_auto = reply_auto;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Clock, watchdog
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Request side: bursts of random length, random gaps between them.
	// tvalid stays high across back-to-back requests within a burst.
	// ---------------------------------------------------------------------
	task automatic send_tick(bit level, bit hot, bit hb, bit en, logic [SeqW-1:0] seq);
		int unsigned gap;
		cs_item_t    it;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, seq, en, hb, hot, level};
		do @(posedge clk); while (!s_tready);
		it.switch_level = level;
		it.overheat = hot;
		it.hb_arrived = hb;
		it.hb_enable = en;
		it.hb_seq = seq;
		expected_results.push_back(supervise_tick(it));
	endtask

	// every request yields one result, so an empty queue means idle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// setup cycle, access cycle; register takes the value on the access edge
	task automatic write_reg(cs_reg_t idx, logic [ApbDataW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PRESS_TIME:      lim_press = val[HoldW-1:0];
			REG_LONG_PRESS_TIME: lim_long = val[HoldW-1:0];
			REG_HB_LIMIT:        lim_hb = val[SilW-1:0];
			REG_MANUAL_LIMIT:    lim_man = val[ManW-1:0];
		endcase
	endtask

	task automatic set_limits(int unsigned press, int unsigned long_press, int unsigned hb,
			int unsigned man);
		drain_results();
		write_reg(REG_PRESS_TIME, press);
		write_reg(REG_LONG_PRESS_TIME, long_press);
		write_reg(REG_HB_LIMIT, hb);
		write_reg(REG_MANUAL_LIMIT, man);
	endtask

	// ---------------------------------------------------------------------
	// Random mixes: mostly press episodes and heartbeat trains shaped around
	// the current limits, with a little pure noise.
	// ---------------------------------------------------------------------
	function automatic int capped(int v, int cap);
		return (v > cap) ? cap : v;
	endfunction

	// one tick at a given switch level, sporadic heartbeat, rare overheat
	task automatic noisy_tick(bit level);
		send_tick(level, $urandom_range(0, 23) == 0, $urandom_range(0, 4) == 0,
			$urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
		budget--;
	endtask

	task automatic run_mix(int n, int cap);
		int kind;
		int len;
		int k;
		budget = n;
		while (budget > 0) begin
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				// switch held low, then released; aimed near the press thresholds
				case ($urandom_range(0, 2))
					0: len = $urandom_range(1, capped(int'(lim_press) + 2, cap));
					1: len = $urandom_range(capped(int'(lim_press), cap),
						capped(int'(lim_long) + 3, cap));
					default: len = $urandom_range(capped(int'(lim_long), cap),
						capped(int'(lim_long) + 5, cap));
				endcase
				for (int i = 0; i <= len && budget > 0; i++)
					noisy_tick(1'b0);
				len = $urandom_range(1, 6);
				for (int i = 0; i < len && budget > 0; i++)
					noisy_tick(1'b1);
			end else if (kind <= 7) begin
				// periodic heartbeats around the silence limit
				len = $urandom_range(10, 40);
				k = $urandom_range(1, capped(int'(lim_hb) + 3, 40));
				for (int i = 0; i < len && budget > 0; i++) begin
					send_tick(1'b1, $urandom_range(0, 31) == 0, (i % k) == k - 1,
						$urandom_range(0, 7) != 0, 8'($urandom_range(0, 255)));
					budget--;
				end
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len && budget > 0; i++) begin
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
					budget--;
				end
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// hand-placed ticks: push after one, long after three, two quiet ticks allowed
	task automatic test_directed();
		set_limits(1, 3, 2, 2);
		send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);   // first sample latched
		send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'hFF);   // heartbeat arms auto
		send_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'h00);   // overheat in auto, arm refused
		send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'hA5);   // re-arm clears fault
		repeat (3) send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);  // heartbeat timeout
		send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'h3C);
		repeat (2) send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
		send_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);   // timeout and overheat together
		repeat (3) send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);  // push -> manual
		send_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h5A);   // heartbeat ignored in manual
		send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);   // long push stops charging
		repeat (2) send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);  // release
		send_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'h81);   // heartbeat asking off
		repeat (3) send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);  // push again
		send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);   // release tick still a push
		repeat (3) send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);  // manual timeout
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_backpressure();
		set_limits(3, 12, 8, 20);
		hold_off_req = 1'b1;
		run_mix(600, 40);
	endtask

	// everything qualifies or times out at once
	task automatic test_zero_limits();
		set_limits(0, 0, 0, 0);
		run_mix(200, 40);
	endtask

	// immediate push, never long, never a timeout
	task automatic test_max_limits();
		set_limits(0, 32'hFFFF, 32'hFFFF, 32'hFFFFFF);
		run_mix(200, 40);
	endtask

	// long threshold below the push threshold: hold goes straight to long
	task automatic test_inverted_limits();
		set_limits(32'hFFFF, 4, 6, 30);
		run_mix(300, 40);
	endtask

	// power-on values written back; one hold long enough to qualify a push
	task automatic test_reset_limits();
		set_limits(32'(PressTimeRst), 32'(LongPressTimeRst), 32'(HbLimitRst),
			32'(ManualLimitRst));
		budget = 0;
		repeat (int'(lim_press) + 4) noisy_tick(1'b0);
		repeat (3) noisy_tick(1'b1);
		run_mix(80, 40);
	endtask

	// ---------------------------------------------------------------------
	// Result side: stall pattern per stretch, plus one requested hold-off
	// ---------------------------------------------------------------------
	initial begin
		int unsigned stretch;
		int unsigned style;
		int unsigned pos;
		logic [7:0]  mask;
		stretch = 0;
		style = 0;
		pos = 0;
		mask = 8'hFF;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(20, 120);
					style = $urandom_range(0, 2);
					mask = 8'($urandom_range(1, 255));
				end
				stretch--;
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: begin
						m_tready <= mask[pos[2:0]];
						pos++;
					end
				endcase
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cs_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: %h", m_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("ac_relay", 32'(want.ac_relay), 32'(m_tdata[0]));
				check_field("dc_relay", 32'(want.dc_relay), 32'(m_tdata[1]));
				check_field("fan_on", 32'(want.fan_on), 32'(m_tdata[2]));
				check_field("manual_active", 32'(want.manual_active), 32'(m_tdata[3]));
				check_field("auto_active", 32'(want.auto_active), 32'(m_tdata[4]));
				check_field("fault_code", 32'(want.fault_code), 32'(m_tdata[6:5]));
				check_field("press_state", 32'(want.press_state), 32'(m_tdata[8:7]));
				check_field("reply_valid", 32'(want.reply_valid), 32'(m_tdata[9]));
				check_field("reply_seq", 32'(want.reply_seq), 32'(m_tdata[17:10]));
				check_field("reply_auto", 32'(want.reply_auto), 32'(m_tdata[18]));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		mismatches = 0;
		cycles = 0;
		burst_left = 0;
		budget = 0;
		hold_off_req = 1'b0;
		reset_charger();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_zero_limits();
		test_max_limits();
		test_inverted_limits();
		test_reset_limits();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/cs_pkg.sv
hw/rtl/cs_step.sv
hw/rtl/charge_supervisor.sv
bench/charge_supervisor_tb.sv
